@@ rtl/core/chat_pkg.sv @@
package chat_pkg;

	// Angle engine configuration
	localparam int ANGLE_ITERATIONS = 16;
	localparam int ANGLE_FRAC_BITS  = 6;
	localparam int ROOT_STEPS       = 30;
	localparam int CNT_W            = 5;

	// Datapath widths
	localparam int ACC_W  = 27;
	localparam int CW     = 34;
	localparam int ROOT_W = 30;
	localparam int RND_W  = ACC_W + ANGLE_FRAC_BITS + 1;
	localparam int OUTV_W = RND_W - 16;
	localparam int HEAD_W = 15;
	localparam int TILT_W = 14;

	// Angle constants, accumulator in 1/65536 degree
	localparam logic signed [ACC_W-1:0] DEG180 = ACC_W'(180 * 65536);
	localparam logic signed [ACC_W-1:0] DEG360 = ACC_W'(360 * 65536);
	localparam logic [RND_W-1:0]  RND_HALF = RND_W'(32768);
	localparam logic [OUTV_W-1:0] FULL_OUT = OUTV_W'(360 << ANGLE_FRAC_BITS);
	localparam logic [OUTV_W-1:0] HALF_OUT = OUTV_W'(180 << ANGLE_FRAC_BITS);
	localparam logic [OUTV_W-1:0] QUAR_OUT = OUTV_W'(90 << ANGLE_FRAC_BITS);

	// Controller to datapath commands
	typedef struct packed {
		logic             load;
		logic             cor_init_h;
		logic             cor_init_t;
		logic             cor_step;
		logic             h_save;
		logic             sq1;
		logic             sq2;
		logic             root_init;
		logic             root_step;
		logic             t_save;
		logic [CNT_W-1:0] idx;
	} chat_cmd_t;

	// atan(2^-i) in degrees scaled by 65536
	function automatic logic signed [ACC_W-1:0] arc(input logic [CNT_W-1:0] i);
		logic signed [ACC_W-1:0] a;
		case (i)
			5'd0:    a = ACC_W'(2949120);
			5'd1:    a = ACC_W'(1740967);
			5'd2:    a = ACC_W'(919879);
			5'd3:    a = ACC_W'(466945);
			5'd4:    a = ACC_W'(234379);
			5'd5:    a = ACC_W'(117304);
			5'd6:    a = ACC_W'(58666);
			5'd7:    a = ACC_W'(29335);
			5'd8:    a = ACC_W'(14668);
			5'd9:    a = ACC_W'(7334);
			5'd10:   a = ACC_W'(3667);
			5'd11:   a = ACC_W'(1833);
			5'd12:   a = ACC_W'(917);
			5'd13:   a = ACC_W'(458);
			5'd14:   a = ACC_W'(229);
			5'd15:   a = ACC_W'(115);
			5'd16:   a = ACC_W'(57);
			5'd17:   a = ACC_W'(29);
			5'd18:   a = ACC_W'(14);
			5'd19:   a = ACC_W'(7);
			5'd20:   a = ACC_W'(4);
			5'd21:   a = ACC_W'(2);
			5'd22:   a = ACC_W'(1);
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

@@ rtl/core/chat_ctrl.sv @@
module chat_ctrl import chat_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output chat_cmd_t cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_HINIT = 4'd1;
	localparam logic [3:0] S_HCOR  = 4'd2;
	localparam logic [3:0] S_HSAVE = 4'd3;
	localparam logic [3:0] S_SQ1   = 4'd4;
	localparam logic [3:0] S_SQ2   = 4'd5;
	localparam logic [3:0] S_RINIT = 4'd6;
	localparam logic [3:0] S_ROOT  = 4'd7;
	localparam logic [3:0] S_TINIT = 4'd8;
	localparam logic [3:0] S_TCOR  = 4'd9;
	localparam logic [3:0] S_TSAVE = 4'd10;

	logic [3:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q;
	logic             slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Sequencing of the two angle passes and the root
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.idx = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_HINIT;
				end
			end
			S_HINIT: begin
				cmd.cor_init_h = 1'b1;
				cnt_d          = '0;
				state_d        = S_HCOR;
			end
			S_HCOR: begin
				cmd.cor_step = 1'b1;
				if (cnt_q == CNT_W'(ANGLE_ITERATIONS - 1)) begin
					state_d = S_HSAVE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_HSAVE: begin
				cmd.h_save = 1'b1;
				state_d    = S_SQ1;
			end
			S_SQ1: begin
				cmd.sq1 = 1'b1;
				state_d = S_SQ2;
			end
			S_SQ2: begin
				cmd.sq2 = 1'b1;
				state_d = S_RINIT;
			end
			S_RINIT: begin
				cmd.root_init = 1'b1;
				cnt_d         = '0;
				state_d       = S_ROOT;
			end
			S_ROOT: begin
				cmd.root_step = 1'b1;
				if (cnt_q == CNT_W'(ROOT_STEPS - 1)) begin
					state_d = S_TINIT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_TINIT: begin
				cmd.cor_init_t = 1'b1;
				cnt_d          = '0;
				state_d        = S_TCOR;
			end
			S_TCOR: begin
				cmd.cor_step = 1'b1;
				if (cnt_q == CNT_W'(ANGLE_ITERATIONS - 1)) begin
					state_d = S_TSAVE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_TSAVE: begin
				// hold until the output register can take the result
				if (slot_free) begin
					cmd.t_save = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.t_save) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.t_save |-> (!out_valid_q || out_ready))
		else $error("result written over a pending transaction");
	a_hcor_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HCOR && cnt_q == CNT_W'(ANGLE_ITERATIONS - 1)) |=> state_q == S_HSAVE)
		else $error("heading pass did not finish");
	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ROOT |-> cnt_q < CNT_W'(ROOT_STEPS))
		else $error("root step count out of range");
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == S_HINIT)
		else $error("accepted transaction did not start work");
`endif

endmodule

@@ rtl/core/chat_dp.sv @@
module chat_dp import chat_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  chat_cmd_t          cmd,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic               accel_ok,
	input  logic signed [15:0] mag_x,
	input  logic signed [15:0] mag_y,
	input  logic               mag_ok,
	output logic [HEAD_W-1:0]  heading,
	output logic [TILT_W-1:0]  tilt
);

	logic signed [15:0] ax_q, ay_q, az_q, mx_q, my_q;

	logic signed [CW-1:0]    cx_q, cy_q;
	logic signed [ACC_W-1:0] cz_q;
	logic                    zr_q;
	logic signed [CW-1:0]    x0, y0, xs, ys;
	logic signed [ACC_W-1:0] at;

	logic [31:0]         p_q, sq_q;
	logic [59:0]         n_q;
	logic [30:0]         rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [32:0]         remn, trial;

	logic signed [ACC_W-1:0] hz, tz;
	logic [RND_W-1:0]        rnd_h, rnd_t;
	logic [OUTV_W-1:0]       hv, tv;
	logic [HEAD_W-1:0]       hd_q, heading_q;
	logic [TILT_W-1:0]       tilt_q;
	logic                    acc_zero;

	// Held sensor words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q <= '0;
			ay_q <= '0;
			az_q <= '0;
			mx_q <= '0;
			my_q <= '0;
		end else if (cmd.load) begin
			if (accel_ok) begin
				ax_q <= accel_x;
				ay_q <= accel_y;
				az_q <= accel_z;
			end
			if (mag_ok) begin
				mx_q <= mag_x;
				my_q <= mag_y;
			end
		end
	end

	// CORDIC start vector, inputs scaled by 2^14
	always_comb begin
		if (cmd.cor_init_t) begin
			x0 = {{4{az_q[15]}}, az_q, 14'b0};
			y0 = {4'b0, root_q};
		end else begin
			x0 = {{4{mx_q[15]}}, mx_q, 14'b0};
			y0 = {{4{my_q[15]}}, my_q, 14'b0};
		end
	end

	assign xs = cx_q >>> cmd.idx;
	assign ys = cy_q >>> cmd.idx;
	assign at = arc(cmd.idx);

	// Digit-by-digit root trial
	assign remn  = {rem_q, n_q[59:58]};
	assign trial = {1'b0, root_q, 2'b01};

	// Heading: wrap, round, fold 360 back to 0
	always_comb begin
		hz = zr_q ? '0 : cz_q;
		if (hz < 0) begin
			hz = hz + DEG360;
		end
		if (hz < 0) begin
			hz = '0;
		end
		rnd_h = ({{(RND_W-ACC_W){1'b0}}, hz} << ANGLE_FRAC_BITS) + RND_HALF;
		hv    = rnd_h[RND_W-1:16];
		if (hv >= FULL_OUT) begin
			hv = hv - FULL_OUT;
		end
	end

	// Tilt: clamp to 0..180, round, zero vector gives 90
	assign acc_zero = (ax_q == 16'sd0) && (ay_q == 16'sd0) && (az_q == 16'sd0);
	always_comb begin
		tz = zr_q ? '0 : cz_q;
		if (tz < 0) begin
			tz = '0;
		end
		if (tz > DEG180) begin
			tz = DEG180;
		end
		rnd_t = ({{(RND_W-ACC_W){1'b0}}, tz} << ANGLE_FRAC_BITS) + RND_HALF;
		tv    = rnd_t[RND_W-1:16];
		if (tv > HALF_OUT) begin
			tv = HALF_OUT;
		end
		if (acc_zero) begin
			tv = QUAR_OUT;
		end
	end

	// Shared CORDIC, square sum, root and result registers
	always_ff @(posedge clk) begin
		if (cmd.cor_init_h || cmd.cor_init_t) begin
			zr_q <= (x0 == '0) && (y0 == '0);
			if (x0 < 0) begin
				cx_q <= -x0;
				cy_q <= -y0;
				cz_q <= DEG180;
			end else begin
				cx_q <= x0;
				cy_q <= y0;
				cz_q <= '0;
			end
		end else if (cmd.cor_step) begin
			if (cy_q > 0) begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				cz_q <= cz_q + at;
			end else begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				cz_q <= cz_q - at;
			end
		end
		if (cmd.h_save) begin
			hd_q <= hv[HEAD_W-1:0];
		end
		if (cmd.sq1) begin
			p_q <= 32'(ax_q * ax_q);
		end
		if (cmd.sq2) begin
			sq_q <= p_q + 32'(ay_q * ay_q);
		end
		if (cmd.root_init) begin
			n_q    <= {sq_q, 28'b0};
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.root_step) begin
			n_q <= {n_q[57:0], 2'b00};
			if (remn >= trial) begin
				rem_q  <= 31'(remn - trial);
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= remn[30:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
		if (cmd.t_save) begin
			heading_q <= hd_q;
			tilt_q    <= tv[TILT_W-1:0];
		end
	end

	assign heading = heading_q;
	assign tilt    = tilt_q;

endmodule

@@ rtl/core/compass_heading_and_tilt_core.sv @@
// An input transaction is accepted only while the controller is idle; each one
// is worked through in two 16-step passes of the shared CORDIC unit and the
// 30-step bit-serial square root before the result is written out.
// A finished result waits in the output register while the next is accepted.
// Reset (arst_n, asynchronous, active low) clears the held sensor words,
// the controller state and the output valid flag.
module compass_heading_and_tilt_core import chat_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic               accel_ok,
	input  logic signed [15:0] mag_x,
	input  logic signed [15:0] mag_y,
	input  logic               mag_ok,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [HEAD_W-1:0]  heading,
	output logic [TILT_W-1:0]  tilt
);

	chat_cmd_t cmd;

	chat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	chat_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.accel_x  (accel_x),
		.accel_y  (accel_y),
		.accel_z  (accel_z),
		.accel_ok (accel_ok),
		.mag_x    (mag_x),
		.mag_y    (mag_y),
		.mag_ok   (mag_ok),
		.heading  (heading),
		.tilt     (tilt)
	);

endmodule

@@ bench/tb_compass_heading_and_tilt_core.sv @@
`timescale 1ns / 100ps

module tb_compass_heading_and_tilt_core;
	import chat_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [15:0] accel_x, accel_y, accel_z, mag_x, mag_y;
	logic accel_ok, mag_ok;
	logic out_valid;
	logic out_ready;
	logic [HEAD_W-1:0] heading;
	logic [TILT_W-1:0] tilt;

	typedef struct packed {
		logic [HEAD_W-1:0] heading;
		logic [TILT_W-1:0] tilt;
	} angles_t;

	angles_t angle_queue[$];
	int errors;
	int sent;
	int received;
	bit sending_done;

	// held sensor words, mirror of the block's holding registers
	logic signed [15:0] hold_ax, hold_ay, hold_az, hold_mx, hold_my;

	// atan(2^-i) in degrees, scaled by 65536
	localparam longint ARCTAN[24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	compass_heading_and_tilt_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z), .accel_ok(accel_ok),
		.mag_x(mag_x), .mag_y(mag_y), .mag_ok(mag_ok),
		.out_valid(out_valid), .out_ready(out_ready),
		.heading(heading), .tilt(tilt)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic longint shift_floor(longint v, int k);
		return v >>> k;
	endfunction

	function automatic longint isqrt(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(res);
	endfunction

	// CORDIC vectoring angle, 1/65536 degree units
	function automatic longint cordic_angle(longint x, longint y);
		longint acc, xs, ys;
		acc = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			acc = 180 * 65536;
		end
		for (int i = 0; i < ANGLE_ITERATIONS && i < 24; i++) begin
			xs = shift_floor(x, i);
			ys = shift_floor(y, i);
			if (y > 0) begin
				x += ys;
				y -= xs;
				acc += ARCTAN[i];
			end else begin
				x -= ys;
				y += xs;
				acc -= ARCTAN[i];
			end
		end
		return acc;
	endfunction

	function automatic longint unsigned to_units(longint a);
		longint unsigned u;
		u = longint'(a);
		return (u * (64'd1 << ANGLE_FRAC_BITS) + 64'd32768) >> 16;
	endfunction

	// work out the angles for one sample set, updating the held words
	function automatic angles_t compute_angles(logic signed [15:0] ax, logic signed [15:0] ay,
			logic signed [15:0] az, logic aok, logic signed [15:0] mx,
			logic signed [15:0] my, logic mok);
		angles_t r;
		longint h, t, rr;
		longint unsigned hu, tu, sq;
		if (aok) begin
			hold_ax = ax;
			hold_ay = ay;
			hold_az = az;
		end
		if (mok) begin
			hold_mx = mx;
			hold_my = my;
		end
		h = cordic_angle(longint'(hold_mx) * 16384, longint'(hold_my) * 16384);
		if (h < 0)
			h += 360 * 65536;
		if (h < 0)
			h = 0;
		hu = to_units(h);
		while (hu >= (64'd360 << ANGLE_FRAC_BITS))
			hu -= (64'd360 << ANGLE_FRAC_BITS);
		if (hold_ax == 0 && hold_ay == 0 && hold_az == 0) begin
			tu = 64'd90 << ANGLE_FRAC_BITS;
		end else begin
			sq = longint'(hold_ax) * hold_ax + longint'(hold_ay) * hold_ay;
			rr = isqrt(sq << 28);
			t = cordic_angle(longint'(hold_az) * 16384, rr);
			if (t < 0)
				t = 0;
			if (t > 180 * 65536)
				t = 180 * 65536;
			tu = to_units(t);
			if (tu > (64'd180 << ANGLE_FRAC_BITS))
				tu = 64'd180 << ANGLE_FRAC_BITS;
		end
		r.heading = hu[HEAD_W-1:0];
		r.tilt = tu[TILT_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		$display("mismatch on %s at %0t: got %0d, expected %0d", what, $time, got, want);
	endtask

	function automatic int gap_length();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 120);
		return $urandom_range(0, 3);
	endfunction

	bit no_gaps;

	// send one sample set as a transaction; called at a falling edge
	task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
			logic signed [15:0] az, logic aok, logic signed [15:0] mx,
			logic signed [15:0] my, logic mok);
		int g;
		g = no_gaps ? 0 : gap_length();
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		accel_x <= ax;
		accel_y <= ay;
		accel_z <= az;
		accel_ok <= aok;
		mag_x <= mx;
		mag_y <= my;
		mag_ok <= mok;
		in_valid <= 1'b1;
		angle_queue.push_back(compute_angles(ax, ay, az, aok, mx, my, mok));
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	// output side: random stalls, compare against the oldest expectation
	initial begin
		angles_t want;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (no_gaps)
				out_ready <= 1'b1;
			else
				out_ready <= ($urandom_range(0, 9) < 7) ? 1'b1 : ($urandom_range(0, 19) == 0);
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				received++;
				if (angle_queue.size() == 0) begin
					report_mismatch("unexpected result", heading, -1);
				end else begin
					want = angle_queue.pop_front();
					if (heading !== want.heading)
						report_mismatch("heading", heading, want.heading);
					if (tilt !== want.tilt)
						report_mismatch("tilt", tilt, want.tilt);
				end
			end
		end
	end

	// extremes, zero vectors and the four quadrants
	task automatic test_directed();
		send_sample(0, 0, 0, 1, 0, 0, 1);
		send_sample(0, 0, 16384, 1, 100, 0, 1);
		send_sample(0, 0, -16384, 1, 0, 100, 1);
		send_sample(16384, 0, 0, 1, -100, 0, 1);
		send_sample(-32768, -32768, -32768, 1, 0, -100, 1);
		send_sample(32767, 32767, 32767, 1, 32767, 32767, 1);
		send_sample(-32768, 32767, 0, 1, -32768, -32768, 1);
		send_sample(0, 0, 32767, 1, -32768, 32767, 1);
		send_sample(0, 0, -32768, 1, 32767, -32768, 1);
		send_sample(1, 0, 0, 1, 32767, -1, 1);
		send_sample(0, 0, 1, 1, 1000, -1, 1);
		send_sample(0, 0, -1, 1, -1, 0, 1);
		send_sample(5, -7, 3, 0, 3, 4, 0);
		send_sample(1234, -999, 55, 1, -1, 1, 0);
		send_sample(0, 0, 0, 1, 0, 0, 0);
		send_sample(-1, -1, -1, 0, 0, 0, 1);
		send_sample(16'h5555, 16'hAAAA, 16'h5555, 1, 16'hAAAA, 16'h5555, 1);
		send_sample(16'hAAAA, 16'h5555, 16'hAAAA, 1, 16'h5555, 16'hAAAA, 1);
	endtask

	function automatic logic signed [15:0] rand_word();
		case ($urandom_range(0, 4))
			0: return 16'($urandom_range(0, 15) - 8);
			1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_random(int count);
		for (int i = 0; i < count; i++)
			send_sample(rand_word(), rand_word(), rand_word(), $urandom_range(0, 3) != 0,
				rand_word(), rand_word(), $urandom_range(0, 3) != 0);
	endtask

	// back to back with no idling on either side
	task automatic test_full_rate();
		no_gaps = 1'b1;
		test_random(60);
		no_gaps = 1'b0;
	endtask

	initial begin
		errors = 0;
		sent = 0;
		received = 0;
		no_gaps = 1'b0;
		hold_ax = 0;
		hold_ay = 0;
		hold_az = 0;
		hold_mx = 0;
		hold_my = 0;
		in_valid = 1'b0;
		{accel_x, accel_y, accel_z, mag_x, mag_y} = '0;
		accel_ok = 1'b0;
		mag_ok = 1'b0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random(740);
		test_full_rate();
		in_valid <= 1'b0;
		while (angle_queue.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("sent %0d sample sets, checked %0d heading and tilt results", sent, received);
		$display("covered zero vectors, full-scale words, held sensor words, stalls");
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// run limit
	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/chat_pkg.sv
rtl/core/chat_ctrl.sv
rtl/core/chat_dp.sv
rtl/core/compass_heading_and_tilt_core.sv
bench/tb_compass_heading_and_tilt_core.sv
